FILE: rtl/ssl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_pkg: shared types and constants of the sender slot LRU table
// Holds the sender record that moves through the input queue and the slot
// store, and the default sizes of the table and of the queue.
// ----------------------------------------------------------------------------
package ssl_pkg;

    // Default number of sender slots
    localparam int SLOTS_DEF = 8;

    // Entries of the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // One arriving sender; also the word kept in the slot store
    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] now_ms;
    } t_item;

endpackage
`default_nettype wire

FILE: rtl/ssl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ssl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/ssl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_queue: front of the sender slot table
// Accepts arriving senders and holds them in a short queue until the lookup
// engine takes them, so input transfers continue while the engine is busy.
// ----------------------------------------------------------------------------
module ssl_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input channel
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ssl_pkg::t_item i_item,
    // toward the engine
    output logic               o_q_valid,
    output ssl_pkg::t_item     o_q_item,
    input  wire logic          i_q_pop
);

    localparam int PW = (ssl_pkg::QUEUE_DEPTH > 1) ? $clog2(ssl_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(ssl_pkg::QUEUE_DEPTH + 1);

    ssl_pkg::t_item r_buf [ssl_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           push;
    logic           pop;

    assign o_ready   = (r_count != CW'(ssl_pkg::QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_buf[r_rd_ptr];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(ssl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(ssl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store an accepted transfer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ssl_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_engine: back of the sender slot table
// Takes one sender from the queue, scans the slot store one slot per cycle
// for a hit, the first free slot and the least recently used slot, then
// updates the chosen slot and presents the result in an output register.
// ----------------------------------------------------------------------------
module ssl_engine #(
    parameter int SLOTS = ssl_pkg::SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // from the queue
    input  wire logic           i_q_valid,
    input  wire ssl_pkg::t_item i_q_item,
    output logic                o_q_pop,
    // result channel
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [2:0]          o_slot_index,
    output logic                o_hit,
    output logic                o_evicted
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int DW = $bits(ssl_pkg::t_item);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]     r_state, n_state;
    ssl_pkg::t_item r_item, n_item;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_pend, n_pend;
    logic [IW-1:0]  r_pend_idx, n_pend_idx;
    logic           r_hit, n_hit;
    logic [IW-1:0]  r_hit_idx, n_hit_idx;
    logic           r_free, n_free;
    logic [IW-1:0]  r_free_idx, n_free_idx;
    logic           r_lru_set, n_lru_set;
    logic [31:0]    r_lru_time, n_lru_time;
    logic [IW-1:0]  r_lru_idx, n_lru_idx;
    logic [SLOTS-1:0] r_active, n_active;
    logic           r_out_vld, n_out_vld;
    logic [2:0]     r_out_idx, n_out_idx;
    logic           r_out_hit, n_out_hit;
    logic           r_out_evict, n_out_evict;

    logic           ram_we;
    logic [DW-1:0]  rd_word;
    ssl_pkg::t_item rd_item;
    logic [IW-1:0]  chosen;
    logic           evict;

    assign rd_item = ssl_pkg::t_item'(rd_word);
    assign chosen  = r_hit ? r_hit_idx : (r_free ? r_free_idx : r_lru_idx);
    assign evict   = !r_hit && !r_free;

    // Slot store: address, port and last-use time of every slot
    ssl_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (chosen),
        .i_wdata (r_item),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (rd_word)
    );

    // Sequencer: take, scan, update
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_lru_set   = r_lru_set;
        n_lru_time  = r_lru_time;
        n_lru_idx   = r_lru_idx;
        n_active    = r_active;
        n_out_vld   = r_out_vld && !i_ready;
        n_out_idx   = r_out_idx;
        n_out_hit   = r_out_hit;
        n_out_evict = r_out_evict;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;

        case (r_state)
            S_IDLE: begin
                // take the next sender and clear the scan state
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_item    = i_q_item;
                    n_cnt     = '0;
                    n_pend    = 1'b0;
                    n_hit     = 1'b0;
                    n_free    = 1'b0;
                    n_lru_set = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one slot read per cycle
                if (r_cnt != CW'(SLOTS)) begin
                    n_cnt      = r_cnt + 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_cnt[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                // examine the slot read in the previous cycle
                if (r_pend) begin
                    if (r_active[r_pend_idx]) begin
                        if (!r_hit && rd_item.ip == r_item.ip
                                && rd_item.port == r_item.port) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_pend_idx;
                        end
                        if (!r_lru_set || rd_item.now_ms < r_lru_time) begin
                            n_lru_set  = 1'b1;
                            n_lru_time = rd_item.now_ms;
                            n_lru_idx  = r_pend_idx;
                        end
                    end else if (!r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_pend_idx;
                    end
                    if (r_cnt == CW'(SLOTS)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // update the chosen slot once the output register is free
                if (!r_out_vld || i_ready) begin
                    ram_we           = 1'b1;
                    n_active[chosen] = 1'b1;
                    n_out_vld        = 1'b1;
                    n_out_idx        = 3'(chosen);
                    n_out_hit        = r_hit;
                    n_out_evict      = evict;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_active  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_active  <= n_active;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_cnt       <= n_cnt;
        r_pend_idx  <= n_pend_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_lru_set   <= n_lru_set;
        r_lru_time  <= n_lru_time;
        r_lru_idx   <= n_lru_idx;
        r_out_idx   <= n_out_idx;
        r_out_hit   <= n_out_hit;
        r_out_evict <= n_out_evict;
    end

    assign o_valid      = r_out_vld;
    assign o_slot_index = r_out_idx;
    assign o_hit        = r_out_hit;
    assign o_evicted    = r_out_evict;

`ifndef NO_ASSERTIONS
    // A result is never both a hit and an eviction
    a_hit_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_hit && r_out_evict))
        else $error("result flagged as hit and eviction");

    // No read is in flight while waiting for a sender
    a_idle_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("slot read pending in idle");

    // Eviction only when every slot is in use
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && evict) |-> (&r_active))
        else $error("eviction with a free slot");

    // The updated slot is active afterwards
    a_slot_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_active[$past(chosen)])
        else $error("updated slot not active");
`endif

endmodule
`default_nettype wire

FILE: rtl/sender_slot_lru_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sender_slot_lru_table: fully associative sender table with LRU replacement
// Maps each arriving sender (address, port) to one of SLOTS slots, reusing
// its slot on a hit, else taking the first free slot or evicting the least
// recently used one, and stamps the slot with the arrival time.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_ready   i_sender_ip, i_sender_port, i_now_ms
//   result   out        o_valid / i_ready   o_slot_index, o_hit, o_evicted
//
// In the engine an item is taken from the queue, the slot store is scanned one
// slot per cycle through its single registered read port, and the slot is
// updated and the result loaded once the output register is free.
// Reset clears all slots to inactive at once; no clearing pass is needed.
// The input queue takes transfers until full while a result waits for i_ready.
// ----------------------------------------------------------------------------
module sender_slot_lru_table #(
    parameter int SLOTS = ssl_pkg::SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_sender_ip,
    input  wire logic [15:0] i_sender_port,
    input  wire logic [31:0] i_now_ms,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_slot_index,
    output logic             o_hit,
    output logic             o_evicted
);

    ssl_pkg::t_item in_item;
    ssl_pkg::t_item q_item;
    logic           q_valid;
    logic           q_pop;

    assign in_item.ip     = i_sender_ip;
    assign in_item.port   = i_sender_port;
    assign in_item.now_ms = i_now_ms;

    // Front: accept and queue senders
    ssl_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    // Back: look up and update the slot table
    ssl_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_slot_index (o_slot_index),
        .o_hit        (o_hit),
        .o_evicted    (o_evicted)
    );

endmodule
`default_nettype wire

FILE: tb/sender_slot_lru_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sender_slot_lru_table_test: self-checking bench for the sender slot table
// Drives arriving senders through the valid/ready input and checks every
// result transfer against a local model of the LRU slot table or a typed row.
// The run starts with a short directed table and continues with random traffic
// drawn from a small pool of senders, so hits, free-slot fills, evictions, LRU
// ties and wrapped times all occur. Both channels idle at random, and once the
// result side holds off long enough that the input stalls.
// ----------------------------------------------------------------------------
module sender_slot_lru_table_test;

    localparam int SLOTS        = ssl_pkg::SLOTS_DEF;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 4 * SLOTS + 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_MAX     = 16;

    // One expected result transfer
    typedef struct packed {
        logic [2:0] slot;
        logic       hit;
        logic       evicted;
    } t_slot_result;

    // One row of the directed table
    typedef struct {
        ssl_pkg::t_item sender;
        bit             typed;
        t_slot_result   want;
    } t_dir_row;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_SPARSE,
        RX_PERIODIC,
        RX_HALF
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_sender_ip;
    logic [15:0] i_sender_port;
    logic [31:0] i_now_ms;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_slot_index;
    logic        o_hit;
    logic        o_evicted;

    // Table model state
    bit          tbl_active   [SLOTS];
    logic [31:0] tbl_ip       [SLOTS];
    logic [15:0] tbl_port     [SLOTS];
    logic [31:0] tbl_last_use [SLOTS];

    t_slot_result exp_results[$];
    t_dir_row     dir_rows[$];

    // Typed expectation that travels with the item on the input port
    bit           drv_typed;
    t_slot_result drv_want;

    int in_taken;
    int out_taken;
    int in_stalls;
    int err_cnt;
    int hit_cnt;
    int fill_cnt;
    int evict_cnt;
    int cycle_cnt;

    sender_slot_lru_table #(
        .SLOTS(SLOTS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sender_ip   (i_sender_ip),
        .i_sender_port (i_sender_port),
        .i_now_ms      (i_now_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_slot_index  (o_slot_index),
        .o_hit         (o_hit),
        .o_evicted     (o_evicted)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Look up a sender, update the table model and return the result
    task automatic lookup_sender(input logic [31:0] ip, input logic [15:0] port,
                                 input logic [31:0] now_ms, output t_slot_result res);
        int          pick;
        int          free_idx;
        int          lru_idx;
        bit          got_hit;
        bit          got_free;
        bit          lru_seen;
        logic [31:0] lru_time;
        pick     = 0;
        free_idx = 0;
        lru_idx  = 0;
        got_hit  = 1'b0;
        got_free = 1'b0;
        lru_seen = 1'b0;
        lru_time = '0;
        for (int s = 0; s < SLOTS; s++) begin
            if (tbl_active[s]) begin
                if (!got_hit && tbl_ip[s] == ip && tbl_port[s] == port) begin
                    got_hit = 1'b1;
                    pick    = s;
                end
                // strict compare keeps the lowest index on ties
                if (!lru_seen || tbl_last_use[s] < lru_time) begin
                    lru_seen = 1'b1;
                    lru_time = tbl_last_use[s];
                    lru_idx  = s;
                end
            end else if (!got_free) begin
                got_free = 1'b1;
                free_idx = s;
            end
        end
        res.hit     = got_hit;
        res.evicted = 1'b0;
        if (!got_hit) begin
            if (got_free) begin
                pick = free_idx;
            end else begin
                pick        = lru_idx;
                res.evicted = 1'b1;
            end
            tbl_active[pick] = 1'b1;
            tbl_ip[pick]     = ip;
            tbl_port[pick]   = port;
        end
        tbl_last_use[pick] = now_ms;
        res.slot = pick[2:0];
    endtask

    // Append one row to the directed table
    task automatic add_row(input logic [31:0] ip, input logic [15:0] port,
                           input logic [31:0] now_ms, input bit typed,
                           input logic [2:0] slot, input logic hit, input logic evicted);
        t_dir_row row;
        row.sender.ip     = ip;
        row.sender.port   = port;
        row.sender.now_ms = now_ms;
        row.typed         = typed;
        row.want.slot     = slot;
        row.want.hit      = hit;
        row.want.evicted  = evicted;
        dir_rows.push_back(row);
    endtask

    // Offer one sender at a falling edge and hold it until the transfer
    task automatic offer_sender(input ssl_pkg::t_item it, input bit typed,
                                input t_slot_result want);
        int taken_before;
        taken_before  = in_taken;
        i_valid       <= 1'b1;
        i_sender_ip   <= it.ip;
        i_sender_port <= it.port;
        i_now_ms      <= it.now_ms;
        drv_typed     <= typed;
        drv_want      <= want;
        @(negedge i_clk);
        while (in_taken == taken_before) @(negedge i_clk);
    endtask

    // Drop valid for a number of cycles
    task automatic idle_sender(input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Record each input transfer and queue its expected result
    always @(posedge i_clk) begin : input_monitor
        t_slot_result res;
        if (i_rst_n && i_valid && o_ready) begin
            lookup_sender(i_sender_ip, i_sender_port, i_now_ms, res);
            exp_results.push_back(drv_typed ? drv_want : res);
            in_taken++;
            if (res.hit) hit_cnt++;
            else if (res.evicted) evict_cnt++;
            else fill_cnt++;
        end
        if (i_rst_n && i_valid && !o_ready) in_stalls++;
    end

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin : result_monitor
        t_slot_result want;
        if (i_rst_n && o_valid && i_ready) begin
            out_taken++;
            if (exp_results.size() == 0) begin
                $display("%0t: result with no item pending: slot %0d hit %0d evicted %0d",
                         $time, o_slot_index, o_hit, o_evicted);
                err_cnt++;
            end else begin
                want = exp_results.pop_front();
                if (o_slot_index !== want.slot) begin
                    $display("%0t: slot_index expected %0d, got %0d",
                             $time, want.slot, o_slot_index);
                    err_cnt++;
                end
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %0d, got %0d", $time, want.hit, o_hit);
                    err_cnt++;
                end
                if (o_evicted !== want.evicted) begin
                    $display("%0t: evicted expected %0d, got %0d",
                             $time, want.evicted, o_evicted);
                    err_cnt++;
                end
            end
        end
    end

    // Stall the result side on changing patterns, with one long hold-off
    initial begin : ready_pattern
        t_rx_mode mode;
        int       mode_left;
        int       phase;
        bit       held;
        mode      = RX_OPEN;
        mode_left = 0;
        phase     = 0;
        held      = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && in_taken >= HOLD_AFTER) begin
                // long hold-off: the input queue fills and the sender stalls
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_OPEN:     i_ready <= 1'b1;
                    RX_SPARSE:   i_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_ready <= ((phase % 7) >= 2);
                    default:     i_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // End the run if it hangs
    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, exp_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Reset, directed table, random traffic, drain and verdict
    initial begin : stimulus
        ssl_pkg::t_item it;
        t_slot_result   no_want;
        logic [31:0]    pool_ip   [POOL_MAX];
        logic [15:0]    pool_port [POOL_MAX];
        logic [31:0]    now_val;
        int             pool_size;
        int             burst_left;
        int             k;
        int             r;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sender_ip   = '0;
        i_sender_port = '0;
        i_now_ms      = '0;
        drv_typed     = 1'b0;
        drv_want      = '0;
        no_want       = '0;
        in_taken      = 0;
        out_taken     = 0;
        in_stalls     = 0;
        err_cnt       = 0;
        hit_cnt       = 0;
        fill_cnt      = 0;
        evict_cnt     = 0;
        pool_size     = 1;
        burst_left    = 0;
        now_val       = '0;
        for (int s = 0; s < SLOTS; s++) begin
            tbl_active[s]   = 1'b0;
            tbl_ip[s]       = '0;
            tbl_port[s]     = '0;
            tbl_last_use[s] = '0;
        end

        // directed table: typed rows are read straight off the slot order
        add_row(32'h0000_0000, 16'h0000, 32'd0,         1'b1, 3'd0, 1'b0, 1'b0);
        add_row(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 3'd1, 1'b0, 1'b0);
        add_row(32'h0000_0000, 16'h0000, 32'd5,         1'b1, 3'd0, 1'b1, 1'b0);
        add_row(32'h0000_0000, 16'hFFFF, 32'd10,        1'b1, 3'd2, 1'b0, 1'b0);
        add_row(32'hFFFF_FFFF, 16'h0000, 32'd20,        1'b1, 3'd3, 1'b0, 1'b0);
        add_row(32'hA5A5_A5A5, 16'h5A5A, 32'd30,        1'b1, 3'd4, 1'b0, 1'b0);
        add_row(32'h5A5A_5A5A, 16'hA5A5, 32'd40,        1'b1, 3'd5, 1'b0, 1'b0);
        add_row(32'h0F0F_0F0F, 16'hF0F0, 32'd50,        1'b1, 3'd6, 1'b0, 1'b0);
        add_row(32'hF0F0_F0F0, 16'h0F0F, 32'd60,        1'b1, 3'd7, 1'b0, 1'b0);
        // table full: evict the oldest slot
        add_row(32'h1234_5678, 16'h1234, 32'd70,        1'b1, 3'd0, 1'b0, 1'b1);
        // time wrap: a hit stamped with a small time becomes the oldest
        add_row(32'hFFFF_FFFF, 16'hFFFF, 32'd2,         1'b1, 3'd1, 1'b1, 1'b0);
        add_row(32'hDEAD_BEEF, 16'hBEEF, 32'd80,        1'b1, 3'd1, 1'b0, 1'b1);
        // tie on last-use time, then near misses on port and on address
        add_row(32'hF0F0_F0F0, 16'h0F0F, 32'd10,        1'b0, 3'd0, 1'b0, 1'b0);
        add_row(32'h0000_0001, 16'h0001, 32'd90,        1'b0, 3'd0, 1'b0, 1'b0);
        add_row(32'h0000_0000, 16'h0000, 32'd100,       1'b0, 3'd0, 1'b0, 1'b0);
        add_row(32'h1234_5678, 16'h1235, 32'd100,       1'b0, 3'd0, 1'b0, 1'b0);
        add_row(32'h1234_5679, 16'h1234, 32'd110,       1'b0, 3'd0, 1'b0, 1'b0);
        add_row(32'h1234_5678, 16'h1234, 32'd120,       1'b0, 3'd0, 1'b0, 1'b0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // walk the directed table with short random gaps
        foreach (dir_rows[n]) begin
            offer_sender(dir_rows[n].sender, dir_rows[n].typed, dir_rows[n].want);
            idle_sender($urandom_range(0, 2));
        end

        // random traffic from a changing pool of senders
        now_val = 32'd1000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                // rebuild the pool: sizes below and above the table size
                pool_size = $urandom_range(4, 14);
                for (k = 0; k < pool_size; k++) begin
                    r = $urandom_range(0, 3);
                    pool_ip[k]   = $urandom;
                    pool_port[k] = 16'($urandom_range(0, 65535));
                    if (k > 0 && r == 0) pool_ip[k] = pool_ip[k-1];
                    if (k > 0 && r == 1) pool_port[k] = pool_port[k-1];
                end
            end

            // advance time: ties, small steps, jumps and near the wrap
            r = $urandom_range(0, 99);
            if (r < 10) now_val = now_val;
            else if (r < 94) now_val = now_val + $urandom_range(1, 50);
            else if (r < 97) now_val = $urandom;
            else now_val = 32'hFFFF_FFF0 + $urandom_range(0, 15);

            r = $urandom_range(0, 99);
            if (r < 85) begin
                k = $urandom_range(0, pool_size - 1);
                it.ip   = pool_ip[k];
                it.port = pool_port[k];
            end else if (r < 97) begin
                it.ip   = $urandom;
                it.port = 16'($urandom_range(0, 65535));
            end else begin
                it.ip   = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                it.port = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            it.now_ms = now_val;
            offer_sender(it, 1'b0, no_want);

            // bursts of back-to-back items separated by random gaps
            if (burst_left == 0) begin
                idle_sender($urandom_range(1, 12));
                burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
        idle_sender(1);

        // wait for every result, then watch for stray ones
        while (exp_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d senders: %0d hits, %0d free-slot fills, %0d evictions",
                 in_taken, hit_cnt, fill_cnt, evict_cnt);
        $display("input stalled %0d cycles, incl. a %0d-cycle result hold-off",
                 in_stalls, HOLD_CYCLES);
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
